### rtl/btk_pkg.sv
// Package for the betatron turn map kick block: formats, CORDIC table, helpers.
// Used by every module of the block; depends on nothing.
package btk_pkg;

  localparam int CordicStages = 24;
  localparam int CoordFrac    = 30;
  localparam int TrigFrac     = 30;
  localparam logic signed [33:0] CordicK = 34'sh26DD3B6A;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegTuneX    = 3'd0;
  localparam logic [2:0] RegTuneY    = 3'd1;
  localparam logic [2:0] RegChromX   = 3'd2;
  localparam logic [2:0] RegChromY   = 3'd3;
  localparam logic [2:0] RegCoupling = 3'd4;
  localparam logic [2:0] RegSextN    = 3'd5;
  localparam logic [2:0] RegSextS    = 3'd6;

  // One CORDIC cell's working values.
  typedef struct packed {
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] z;
    logic [1:0]         quad;
  } cordic_t;

  // Arctangent of 2^-i in 1/2^32 turn.
  function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
        5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
        5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
        5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
        5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
        5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
        5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
        5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
        5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
        5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
        5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
        5'd30: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      atan_turns = $signed({2'b00, v});
    end
  endfunction

  // Clamp a wide signed value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    begin
      if (v > 68'sh0_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
      else if (v < -68'sh0_8000_0000) sat32 = -32'sh8000_0000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

### rtl/betatron_turn_map_kick_top.sv
// Top level of the betatron one-turn map with thin sextupole kick.
// Depends on btk_pkg and btk_sincos.
// Accepts one particle per cycle; done marks each result.
// The CORDIC chain and the multiply stages after it set the latency.
// Synchronous reset clears the configuration registers and the valid pipeline.
// The receiver cannot stall: done pulses for one cycle with each result.
module betatron_turn_map_kick_top import btk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] mom_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] mom_y,
  input  logic signed [31:0] delta_p,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_mom_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_mom_y
);

  localparam int Lat = CordicStages + 9;
  localparam int CordLat = CordicStages + 1;

  logic [31:0] tune_x, tune_y, coupling_gain, sext_normal, sext_skew;
  logic [23:0] chrom_x, chrom_y;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      tune_x <= '0; tune_y <= '0; chrom_x <= '0; chrom_y <= '0;
      coupling_gain <= '0; sext_normal <= '0; sext_skew <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegTuneX:    tune_x <= cfg_data;
        RegTuneY:    tune_y <= cfg_data;
        RegChromX:   chrom_x <= cfg_data[23:0];
        RegChromY:   chrom_y <= cfg_data[23:0];
        RegCoupling: coupling_gain <= cfg_data;
        RegSextN:    sext_normal <= cfg_data;
        RegSextS:    sext_skew <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid pipeline.
  logic [Lat-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[Lat-2:0], start && !busy};
  end
  assign done = vld[Lat-1];

  // Stage 1: delta times chromaticity; stage 2: phase.
  logic signed [55:0] chx_p, chy_p;
  logic [31:0] ph_x, ph_y;
  always_ff @(posedge clk) begin
    chx_p <= delta_p * $signed(chrom_x);
    chy_p <= delta_p * $signed(chrom_y);
    ph_x <= tune_x + 32'(chx_p >>> (CoordFrac - 16));
    ph_y <= tune_y + 32'(chy_p >>> (CoordFrac - 16));
  end

  // Coordinate delay line alongside the CORDIC chain.
  logic signed [31:0] dx [CordLat+2], dpx [CordLat+2], dy [CordLat+2], dpy [CordLat+2];
  always_ff @(posedge clk) begin
    dx[0] <= pos_x; dpx[0] <= mom_x; dy[0] <= pos_y; dpy[0] <= mom_y;
    for (int k = 1; k < CordLat + 2; k++) begin
      dx[k] <= dx[k-1]; dpx[k] <= dpx[k-1]; dy[k] <= dy[k-1]; dpy[k] <= dpy[k-1];
    end
  end

  logic signed [33:0] cx, sx, cy, sy;
  btk_sincos u_sx (.clk(clk), .phase(ph_x), .cos_o(cx), .sin_o(sx));
  btk_sincos u_sy (.clk(clk), .phase(ph_y), .cos_o(cy), .sin_o(sy));

  // Rotation products, then sums.
  logic signed [65:0] pxc, mxs, mxc, pxs, pyc, mys, myc, pys;
  logic signed [31:0] rx, rpx, ry, rpy;
  always_ff @(posedge clk) begin
    pxc <= dx[CordLat+1] * cx;  mxs <= dpx[CordLat+1] * sx;
    mxc <= dpx[CordLat+1] * cx; pxs <= dx[CordLat+1] * sx;
    pyc <= dy[CordLat+1] * cy;  mys <= dpy[CordLat+1] * sy;
    myc <= dpy[CordLat+1] * cy; pys <= dy[CordLat+1] * sy;
    rx  <= sat32(68'((67'(pxc) + 67'(mxs)) >>> TrigFrac));
    rpx <= sat32(68'((67'(mxc) - 67'(pxs)) >>> TrigFrac));
    ry  <= sat32(68'((67'(pyc) + 67'(mys)) >>> TrigFrac));
    rpy <= sat32(68'((67'(myc) - 67'(pys)) >>> TrigFrac));
  end

  // Coupling products and squares.
  logic signed [63:0] gy, gx, xx, yy, xy;
  logic signed [31:0] c_x, c_y, c_px0, c_py0;
  always_ff @(posedge clk) begin
    gy <= $signed(coupling_gain) * ry;
    gx <= $signed(coupling_gain) * rx;
    xx <= rx * rx; yy <= ry * ry; xy <= rx * ry;
    c_x <= rx; c_y <= ry; c_px0 <= rpx; c_py0 <= rpy;
  end

  logic signed [31:0] cp_x, cp_px, cp_y, cp_py, sd, sm;
  always_ff @(posedge clk) begin
    cp_px <= sat32(68'(c_px0) + 68'(gy >>> TrigFrac));
    cp_py <= sat32(68'(c_py0) + 68'(gx >>> TrigFrac));
    sd <= sat32(68'((65'(xx) - 65'(yy)) >>> CoordFrac));
    sm <= sat32(68'(xy >>> CoordFrac));
    cp_x <= c_x; cp_y <= c_y;
  end

  // Sextupole kick products and final sums.
  logic signed [63:0] knd, ksm, ksd, knm;
  logic signed [31:0] k_x, k_px, k_y, k_py;
  always_ff @(posedge clk) begin
    knd <= $signed(sext_normal) * sd; ksm <= $signed(sext_skew) * sm;
    ksd <= $signed(sext_skew) * sd;   knm <= $signed(sext_normal) * sm;
    k_x <= cp_x; k_px <= cp_px; k_y <= cp_y; k_py <= cp_py;
  end

  always_ff @(posedge clk) begin
    new_pos_x <= k_x;
    new_pos_y <= k_y;
    new_mom_x <= sat32(68'(k_px) + 68'(knd >>> 25) - 68'(ksm >>> 24));
    new_mom_y <= sat32(68'(k_py) + 68'(ksd >>> 25) + 68'(knm >>> 24));
  end

  // A result appears exactly one latency after its start.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> ##(Lat-1) done) else $error("result strobe lost");
  a_nobusy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_index == RegTuneX) |=> tune_x == $past(cfg_data))
    else $error("tune_x write lost");

endmodule

### rtl/btk_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation and register per cycle.
// Depends on btk_pkg.
module btk_cordic_cell import btk_pkg::*; (
  input  logic       clk,
  input  logic [4:0] shift,
  input  cordic_t    din,
  output cordic_t    dout
);

  cordic_t res;

  // Rotate toward zero residual angle.
  always_comb begin
    res = din;
    if (!din.z[33]) begin
      res.cx = din.cx - (din.cy >>> shift);
      res.cy = din.cy + (din.cx >>> shift);
      res.z  = din.z - atan_turns(shift);
    end else begin
      res.cx = din.cx + (din.cy >>> shift);
      res.cy = din.cy - (din.cx >>> shift);
      res.z  = din.z + atan_turns(shift);
    end
  end

  always_ff @(posedge clk) begin
    dout <= res;
  end

endmodule

### rtl/btk_sincos.sv
// Chain of CORDIC cells producing cosine and sine of a phase in turns.
// Depends on btk_pkg and btk_cordic_cell; an input register feeds CordicStages registered cells.
module btk_sincos import btk_pkg::*; (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  cordic_t chain [CordicStages+1];
  logic [1:0]  q;
  logic [31:0] resid;

  // Fold to the nearest quarter turn.
  always_comb begin
    q = 2'((phase + 32'h2000_0000) >> 30);
    resid = phase - {q, 30'd0};
  end

  always_ff @(posedge clk) begin
    chain[0].cx   <= CordicK;
    chain[0].cy   <= '0;
    chain[0].z    <= {{2{resid[31]}}, resid};
    chain[0].quad <= q;
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_cell
    btk_cordic_cell u_cell (
      .clk  (clk),
      .shift(5'(i)),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Turn the result back by the quarter turns.
  always_comb begin
    case (chain[CordicStages].quad)
      2'd0: begin cos_o = chain[CordicStages].cx;  sin_o = chain[CordicStages].cy;  end
      2'd1: begin cos_o = -chain[CordicStages].cy; sin_o = chain[CordicStages].cx;  end
      2'd2: begin cos_o = -chain[CordicStages].cx; sin_o = -chain[CordicStages].cy; end
      default: begin cos_o = chain[CordicStages].cy; sin_o = -chain[CordicStages].cx; end
    endcase
  end

endmodule
